// File: rtl/core/vwbp_pkg.sv
// shared types and constants for the variable width bit packer
package vwbp_pkg;

  localparam int MAX_HEADER_BITS_DEF = 6;
  localparam logic [15:0] BUFFER_BYTES_RST = 16'd4096;

  typedef enum logic [2:0] {
    OP_HEADER   = 3'd0,
    OP_UNSIGNED = 3'd1,
    OP_SIGNED   = 3'd2,
    OP_BOOLEAN  = 3'd3,
    OP_FLUSH    = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        last;
    status_t     status;
  } result_t;

endpackage

// File: rtl/core/vwbp_engine.sv
// bit-serial packing engine: one bit into the partial byte per cycle, unless a blocked held word stalls it
module vwbp_engine #(
  parameter int MAX_HEADER_BITS = vwbp_pkg::MAX_HEADER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        opcode,
  input  logic [63:0]       value,
  input  logic [3:0]        header_width,
  input  logic [15:0]       buffer_bytes,
  output logic              idle,
  output logic              push_valid,
  output vwbp_pkg::result_t push_data,
  input  logic              push_ready
);

  localparam int HCW = $clog2(MAX_HEADER_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SHIFT  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                     state;
  logic [63:0]                shreg;
  logic                       sign_bit;
  logic                       sign_pend;
  logic                       by_count;
  logic [HCW-1:0]             hcnt;
  logic                       dropped;
  logic                       reject;
  logic                       pend_valid;
  logic [7:0]                 pend_byte;
  logic [7:0]                 partial;
  logic [2:0]                 bitpos;
  logic [15:0]                bytes_done;

  logic                       cur_bit;
  logic                       full;
  logic                       final_bit;
  logic                       byte_done;
  logic                       step_block;
  logic [7:0]                 new_byte;
  logic [MAX_HEADER_BITS-1:0] hdr;
  logic                       hdr_bad;

  assign idle = (state == S_IDLE);
  assign hdr  = value[MAX_HEADER_BITS-1:0] - MAX_HEADER_BITS'(1);
  assign hdr_bad = (value == 64'd0) || (header_width == 4'd0) ||
                   (header_width > 4'(MAX_HEADER_BITS));

  always_comb begin
    cur_bit    = sign_pend ? sign_bit : shreg[0];
    full       = (bytes_done >= buffer_bytes);
    // magnitude ends once nothing significant is left above the current bit; a header ends on its last counted bit
    final_bit  = by_count ? (hcnt == HCW'(1)) : (!sign_pend && (shreg[63:1] == 63'd0));
    byte_done  = !full && (bitpos == 3'd7);
    new_byte   = partial;
    new_byte[7] = cur_bit;
    step_block = byte_done && pend_valid && !push_ready;

    push_valid = 1'b0;
    push_data  = '0;
    unique case (state)
      S_SHIFT: begin
        // a fresh word displaces the held one, which cannot be the last
        if (byte_done && pend_valid) begin
          push_valid = 1'b1;
          push_data.byte_valid = 1'b1;
          push_data.out_byte   = pend_byte;
          push_data.last       = 1'b0;
          push_data.status     = vwbp_pkg::ST_OK;
        end
      end
      S_FINISH: begin
        push_valid = 1'b1;
        if (pend_valid) begin
          push_data.byte_valid = 1'b1;
          push_data.out_byte   = pend_byte;
          push_data.last       = !dropped;
          push_data.status     = vwbp_pkg::ST_OK;
        end else begin
          push_data.byte_valid = 1'b0;
          push_data.out_byte   = 8'd0;
          push_data.last       = 1'b1;
          if (dropped) begin
            push_data.status = vwbp_pkg::ST_OVERFLOW;
          end else if (reject) begin
            push_data.status = vwbp_pkg::ST_REJECT;
          end else begin
            push_data.status = vwbp_pkg::ST_OK;
          end
        end
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      partial    <= 8'd0;
      bitpos     <= 3'd0;
      bytes_done <= 16'd0;
      dropped    <= 1'b0;
      reject     <= 1'b0;
      sign_pend  <= 1'b0;
      by_count   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            dropped   <= 1'b0;
            reject    <= 1'b0;
            sign_pend <= 1'b0;
            by_count  <= 1'b0;
            unique case (opcode)
              vwbp_pkg::OP_HEADER: begin
                if (hdr_bad) begin
                  reject <= 1'b1;
                  state  <= S_FINISH;
                end else begin
                  shreg    <= 64'(hdr);
                  hcnt     <= HCW'(header_width);
                  by_count <= 1'b1;
                  state    <= S_SHIFT;
                end
              end
              vwbp_pkg::OP_UNSIGNED: begin
                shreg <= value;
                state <= S_SHIFT;
              end
              vwbp_pkg::OP_SIGNED: begin
                sign_bit  <= value[63];
                sign_pend <= 1'b1;
                shreg     <= value[63] ? (64'd0 - value) : value;
                state     <= S_SHIFT;
              end
              vwbp_pkg::OP_BOOLEAN: begin
                shreg <= {63'd0, (value != 64'd0)};
                state <= S_SHIFT;
              end
              vwbp_pkg::OP_FLUSH: begin
                pend_valid <= (bitpos != 3'd0);
                pend_byte  <= partial;
                partial    <= 8'd0;
                bitpos     <= 3'd0;
                bytes_done <= 16'd0;
                state      <= S_FINISH;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (!step_block) begin
            if (full) begin
              dropped <= 1'b1;
            end else if (byte_done) begin
              pend_byte  <= new_byte;
              pend_valid <= 1'b1;
              partial    <= 8'd0;
              bitpos     <= 3'd0;
              bytes_done <= bytes_done + 16'd1;
            end else begin
              partial[bitpos] <= cur_bit;
              bitpos          <= bitpos + 3'd1;
            end
            if (sign_pend) begin
              sign_pend <= 1'b0;
            end else begin
              shreg <= shreg >> 1;
            end
            if (by_count) begin
              hcnt <= hcnt - HCW'(1);
            end
            if (final_bit) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (push_ready) begin
            if (pend_valid) begin
              pend_valid <= 1'b0;
              // after an overflow the status word still has to follow
              if (!dropped) begin
                state <= S_IDLE;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("held word left over at end of item");

  a_no_push_idle: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (state != S_IDLE))
    else $error("result pushed while idle");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SHIFT) && by_count) |-> (hcnt != '0))
    else $error("header bit count ran out");

  a_status_word_last: assert property (@(posedge clk) disable iff (rst)
    (push_valid && !push_data.byte_valid) |-> push_data.last)
    else $error("status word not marked last");

  a_byte_wrap: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SHIFT) && !step_block && byte_done) |=> (bitpos == 3'd0))
    else $error("bit position not cleared after a full word");

endmodule

// File: rtl/core/variable_width_bit_packer_top.sv
// top level of the variable width bit packer: handshakes, register, output stage
//
//   channel   direction  handshake          contents
//   in        input      in_valid/in_stall  opcode, value, header_width
//   out       output     out_valid/out_stall byte_valid, out_byte, last, status
//   cfg       input      cfg_valid/cfg_ready cfg_data (buffer_bytes)
//
// an item is loaded, then packed one bit per cycle unless a blocked held word
// stalls it (up to 65 bits for a signed value), then closed by one or two words;
// the shift register moves one bit at a time
// a finished word is held in the engine until the next one completes or the item ends;
// packing pauses only while that held word is blocked by a stalled output register
// reset is synchronous and needs no clearing pass; buffer_bytes returns to 4096
module variable_width_bit_packer_top #(
  parameter int MAX_HEADER_BITS = vwbp_pkg::MAX_HEADER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [63:0] value,
  input  logic [3:0]  header_width,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        byte_valid,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]       buffer_bytes;
  logic              eng_idle;
  logic              push_valid;
  logic              push_ready;
  vwbp_pkg::result_t push_data;
  vwbp_pkg::result_t out_reg;

  assign in_stall   = !eng_idle;
  assign cfg_ready  = eng_idle;
  assign push_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes <= vwbp_pkg::BUFFER_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      buffer_bytes <= cfg_data;
    end
  end

  vwbp_engine #(
    .MAX_HEADER_BITS (MAX_HEADER_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (in_valid && !in_stall),
    .opcode       (opcode),
    .value        (value),
    .header_width (header_width),
    .buffer_bytes (buffer_bytes),
    .idle         (eng_idle),
    .push_valid   (push_valid),
    .push_data    (push_data),
    .push_ready   (push_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_valid && push_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      out_reg <= push_data;
    end
  end

  assign byte_valid = out_reg.byte_valid;
  assign out_byte   = out_reg.out_byte;
  assign last       = out_reg.last;
  assign status     = out_reg.status;

endmodule

// File: test/variable_width_bit_packer_checker.sv
// checker for the variable width bit packer: predicts the packed words and compares them
module variable_width_bit_packer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [63:0] value,
  input  logic [3:0]  header_width,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        byte_valid,
  input  logic [7:0]  out_byte,
  input  logic        last,
  input  logic [1:0]  status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEADER_BITS_MAX = vwbp_pkg::MAX_HEADER_BITS_DEF;

  logic [15:0] capacity;
  logic [7:0]  acc_byte;
  logic [2:0]  acc_pos;
  logic [15:0] acc_bytes;
  bit          acc_dropped;

  vwbp_pkg::result_t word_expect_q[$];
  vwbp_pkg::result_t item_words[$];

  task automatic note_word(input logic bv, input logic [7:0] b, input vwbp_pkg::status_t st);
    vwbp_pkg::result_t w;
    w.byte_valid = bv;
    w.out_byte   = b;
    w.last       = 1'b0;
    w.status     = st;
    item_words.push_back(w);
  endtask

  task automatic pack_bit(input logic b);
    // nothing goes in once the buffer holds its capacity
    if (acc_bytes >= capacity) begin
      acc_dropped = 1'b1;
      return;
    end
    acc_byte[acc_pos] = b;
    if (acc_pos == 3'd7) begin
      note_word(1'b1, acc_byte, vwbp_pkg::ST_OK);
      acc_byte  = 8'h00;
      acc_pos   = 3'd0;
      acc_bytes = acc_bytes + 16'd1;
    end else begin
      acc_pos = acc_pos + 3'd1;
    end
  endtask

  task automatic pack_magnitude(input logic [63:0] m);
    if (m == 64'd0) begin
      pack_bit(1'b0);
    end else begin
      while (m != 64'd0) begin
        pack_bit(m[0]);
        m = m >> 1;
      end
    end
  endtask

  task automatic predict_item(input logic [2:0] op, input logic [63:0] val,
                              input logic [3:0] hw);
    logic [63:0]        h;
    logic               neg;
    vwbp_pkg::status_t  st;
    vwbp_pkg::result_t  w;
    item_words.delete();
    acc_dropped = 1'b0;
    st = vwbp_pkg::ST_OK;
    case (op)
      vwbp_pkg::OP_HEADER: begin
        if (val == 64'd0 || hw == 4'd0 || hw > HEADER_BITS_MAX) begin
          st = vwbp_pkg::ST_REJECT;
        end else begin
          // only the low header_width bits of value minus one go out
          h = val - 64'd1;
          for (int i = 0; i < hw; i++) pack_bit(h[i]);
        end
      end
      vwbp_pkg::OP_UNSIGNED: pack_magnitude(val);
      vwbp_pkg::OP_SIGNED: begin
        neg = val[63];
        pack_bit(neg);
        pack_magnitude(neg ? 64'd0 - val : val);
      end
      vwbp_pkg::OP_BOOLEAN: pack_bit(val != 64'd0);
      vwbp_pkg::OP_FLUSH: begin
        if (acc_pos != 3'd0) note_word(1'b1, acc_byte, vwbp_pkg::ST_OK);
        acc_byte  = 8'h00;
        acc_pos   = 3'd0;
        acc_bytes = 16'd0;
      end
      default: ;
    endcase
    if (acc_dropped) st = vwbp_pkg::ST_OVERFLOW;
    if (item_words.size() == 0 || st != vwbp_pkg::ST_OK) note_word(1'b0, 8'h00, st);
    w = item_words.pop_back();
    w.last = 1'b1;
    item_words.push_back(w);
    foreach (item_words[k]) word_expect_q.push_back(item_words[k]);
  endtask

  always @(posedge clk) begin
    vwbp_pkg::result_t got;
    vwbp_pkg::result_t want;
    if (rst) begin
      capacity   = vwbp_pkg::BUFFER_BYTES_RST;
      acc_byte   = 8'h00;
      acc_pos    = 3'd0;
      acc_bytes  = 16'd0;
      mismatches = 0;
      word_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      // compare before predicting: no word can leave in the cycle its item enters
      if (out_valid && !out_stall) begin
        got.byte_valid = byte_valid;
        got.out_byte   = out_byte;
        got.last       = last;
        got.status     = vwbp_pkg::status_t'(status);
        if (word_expect_q.size() == 0) begin
          mismatches++;
          $display("%t: unexpected word: valid=%b byte=%h last=%b status=%0d",
                   $time, byte_valid, out_byte, last, status);
        end else begin
          want = word_expect_q.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%t: word mismatch: expected valid=%b byte=%h last=%b status=%0d",
                     $time, want.byte_valid, want.out_byte, want.last, want.status);
            $display("%t:                got      valid=%b byte=%h last=%b status=%0d",
                     $time, byte_valid, out_byte, last, status);
          end
        end
      end
      if (in_valid && !in_stall) predict_item(opcode, value, header_width);
    end
    words_pending = word_expect_q.size();
  end

endmodule

// File: test/variable_width_bit_packer_top_tb.sv
// testbench top for the variable width bit packer: clock, reset, stimulus and verdict
module variable_width_bit_packer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RESET_CYCLES  = 9;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          DRAIN_CYCLES  = 80;
  localparam int          LONG_HOLD     = 400;
  localparam int          IDLE_LIMIT    = 6000;
  localparam int          PHASES        = 6;
  localparam int          PHASE_ITEMS   = 24;
  localparam int          HEADER_MAX    = vwbp_pkg::MAX_HEADER_BITS_DEF;
  localparam logic [2:0]  OP_SPARE_LO   = 3'd5;
  localparam logic [2:0]  OP_SPARE_HI   = 3'd7;
  localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MOST_NEG      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [15:0] CAP_MIN       = 16'd1;
  localparam logic [15:0] CAP_MAX       = 16'hFFFF;

  logic        clk;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [2:0]  opcode       = 3'd0;
  logic [63:0] value        = 64'd0;
  logic [3:0]  header_width = 4'd0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic        byte_valid;
  logic [7:0]  out_byte;
  logic        last;
  logic [1:0]  status;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data     = 16'd0;
  int          mismatches;
  int          words_pending;

  bit          burst_mode   = 1'b0;
  bit          hold_req     = 1'b0;

  logic [15:0] phase_cap [PHASES] = '{16'd2, CAP_MAX, CAP_MIN, 16'd24, 16'd300, 16'd5};

  variable_width_bit_packer_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .value        (value),
    .header_width (header_width),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_valid   (byte_valid),
    .out_byte     (out_byte),
    .last         (last),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  variable_width_bit_packer_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    int          len;
    len = $urandom_range(1, 64);
    v   = {$urandom, $urandom} & (ALL_ONES >> (64 - len));
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return ALL_ONES;
      2:       return MOST_NEG;
      3, 4, 5: return {$urandom, $urandom};
      6, 7:    return v;
      default: return 64'd0 - v;
    endcase
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [63:0] val, input logic [3:0] hw);
    int gap;
    int r;
    r   = $urandom_range(0, 99);
    gap = burst_mode ? 0 : (r < 60) ? 0 : (r < 88) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    value        <= val;
    header_width <= hw;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (words_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] cap);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // receiver pacing, with one long hold-off on request so the block backs up
  initial begin : receiver
    bit hold_done;
    int run;
    int r;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        run = LONG_HOLD;
      end else if (r < 45) begin
        out_stall <= 1'b0;
        run = $urandom_range(1, 6);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        run = $urandom_range(1, 3);
      end else if (r < 93) begin
        out_stall <= 1'b1;
        run = $urandom_range(8, 40);
      end else begin
        out_stall <= 1'b0;
        run = $urandom_range(40, 120);
      end
      repeat (run) @(posedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("%t: no handshake for %0d cycles", $time, idle);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [2:0]  op;
    logic [63:0] val;
    logic [3:0]  hw;
    logic [15:0] cap;
    int          r;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // capacity left at its reset value
    send_item(vwbp_pkg::OP_HEADER, 64'd0, 4'd3);
    send_item(vwbp_pkg::OP_HEADER, 64'd5, 4'd0);
    send_item(vwbp_pkg::OP_HEADER, 64'd5, 4'(HEADER_MAX + 1));
    send_item(vwbp_pkg::OP_HEADER, ALL_ONES, 4'hF);
    send_item(vwbp_pkg::OP_HEADER, 64'd1, 4'd1);
    send_item(vwbp_pkg::OP_HEADER, ALL_ONES, 4'(HEADER_MAX));
    send_item(vwbp_pkg::OP_HEADER, 64'd64, 4'(HEADER_MAX));
    send_item(vwbp_pkg::OP_UNSIGNED, 64'd0, 4'd0);
    send_item(vwbp_pkg::OP_UNSIGNED, ALL_ONES, 4'hF);
    send_item(vwbp_pkg::OP_SIGNED, 64'd0, 4'd0);
    send_item(vwbp_pkg::OP_SIGNED, ALL_ONES, 4'd0);
    send_item(vwbp_pkg::OP_SIGNED, MOST_NEG, 4'd0);
    send_item(vwbp_pkg::OP_SIGNED, MOST_POS, 4'd0);
    send_item(vwbp_pkg::OP_BOOLEAN, 64'd0, 4'd0);
    send_item(vwbp_pkg::OP_BOOLEAN, MOST_NEG, 4'd0);
    send_item(vwbp_pkg::OP_FLUSH, 64'd0, 4'd0);
    send_item(vwbp_pkg::OP_FLUSH, 64'd0, 4'd0);
    send_item(OP_SPARE_LO, ALL_ONES, 4'hF);
    send_item(OP_SPARE_HI, 64'd0, 4'd0);

    // capacity lowered to the number of bytes already done, then flushed with bits pending
    write_capacity(CAP_MAX);
    send_item(vwbp_pkg::OP_UNSIGNED, 64'h3FF, 4'd0);
    write_capacity(CAP_MIN);
    send_item(vwbp_pkg::OP_BOOLEAN, 64'd1, 4'd0);
    send_item(vwbp_pkg::OP_UNSIGNED, 64'd5, 4'd0);
    send_item(vwbp_pkg::OP_FLUSH, 64'd0, 4'd0);
    send_item(vwbp_pkg::OP_UNSIGNED, ALL_ONES, 4'd0);
    send_item(vwbp_pkg::OP_FLUSH, 64'd0, 4'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      cap = (ph == PHASES - 1) ? 16'($urandom_range(1, 65535)) : phase_cap[ph];
      write_capacity(cap);
      burst_mode = (ph < 2);
      if (ph == 1) hold_req <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r   = $urandom_range(0, 99);
        hw  = 4'($urandom_range(0, 15));
        val = rand_operand();
        if (r < 18) begin
          op = vwbp_pkg::OP_HEADER;
          if ($urandom_range(0, 9) < 8) hw = 4'($urandom_range(1, HEADER_MAX));
          if ($urandom_range(0, 9) < 8) val = 64'($urandom_range(1, 64));
        end else if (r < 42) begin
          op = vwbp_pkg::OP_UNSIGNED;
        end else if (r < 66) begin
          op = vwbp_pkg::OP_SIGNED;
        end else if (r < 80) begin
          op = vwbp_pkg::OP_BOOLEAN;
        end else if (r < 92) begin
          op = vwbp_pkg::OP_FLUSH;
        end else begin
          op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        send_item(op, val, hw);
      end
    end
    burst_mode = 1'b0;
    in_valid <= 1'b0;

    do @(negedge clk); while (words_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && words_pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
